/* src/ipv4rx_pkg.sv */
// Package: shared types and constants of the IPv4 receive header filter.
`timescale 1ns / 1ps
package ipv4rx_pkg;

  // Default width of the received byte counter
  localparam int LengthBitsDefault = 16;

  // Depth of the record queue between parser and checker
  localparam int RecQueueDepth = 2;

  // Header layout
  localparam logic [3:0] IhlMin          = 4'd5;
  localparam logic [3:0] IpVersion4      = 4'd4;
  localparam logic [15:0] HdrMinBytes    = 16'd20;
  localparam logic [15:0] ChecksumGood   = 16'hFFFF;
  localparam logic [31:0] AllOnesBcast   = 32'hFFFF_FFFF;
  localparam logic [3:0] MulticastPrefix = 4'hE;
  localparam logic [7:0] ProtoIcmp       = 8'd1;
  localparam logic [7:0] ProtoIgmp       = 8'd2;

  // Verdict codes
  localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
  localparam logic [2:0] VERDICT_SHORT     = 3'd1;
  localparam logic [2:0] VERDICT_BAD_IHL   = 3'd2;
  localparam logic [2:0] VERDICT_HDR_ONLY  = 3'd3;
  localparam logic [2:0] VERDICT_CHECKSUM  = 3'd4;
  localparam logic [2:0] VERDICT_NOT_OURS  = 3'd5;
  localparam logic [2:0] VERDICT_FRAGMENT  = 3'd6;
  localparam logic [2:0] VERDICT_TRUNCATED = 3'd7;

  // Queue select codes
  localparam logic [1:0] QUEUE_ICMP    = 2'd0;
  localparam logic [1:0] QUEUE_IGMP    = 2'd1;
  localparam logic [1:0] QUEUE_GENERAL = 2'd2;

  // Configuration register indexes
  localparam int CfgIndexBits = 2;
  localparam logic [CfgIndexBits-1:0] CFG_OWN_ADDRESS     = 2'd0;
  localparam logic [CfgIndexBits-1:0] CFG_DIRECTED_BCAST  = 2'd1;
  localparam logic [CfgIndexBits-1:0] CFG_ICMP_COPY       = 2'd2;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  verdict;
    logic [1:0]  queue_select;
    logic        icmp_copy;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [5:0]  header_bytes;
    logic [15:0] payload_length;
    logic [15:0] padding_bytes;
  } result_t;

  // Configuration seen by the checker
  typedef struct packed {
    logic [31:0] own_address;
    logic [31:0] directed_broadcast;
    logic        icmp_copy_enable;
  } cfg_t;

  // Summary of one packet, passed from parser to checker
  typedef struct packed {
    logic [15:0] byte_count;
    logic [15:0] checksum_sum;
    logic [7:0]  version_ihl;
    logic [15:0] total_length;
    logic [15:0] flags_fragment;
    logic [7:0]  protocol;
    logic [31:0] source;
    logic [31:0] destination;
  } hdr_rec_t;

endpackage

/* src/ipv4rx_front.sv */
// Byte parser: counts bytes, sums the header checksum and latches header fields.
`timescale 1ns / 1ps
module ipv4rx_front #(
  parameter int LENGTH_BITS = ipv4rx_pkg::LengthBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 beat_valid,
  input  ipv4rx_pkg::in_beat_t beat,
  output logic                 rec_push,
  output ipv4rx_pkg::hdr_rec_t rec
);
  import ipv4rx_pkg::*;

  localparam logic [LENGTH_BITS-1:0] CountMax = {LENGTH_BITS{1'b1}};

  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic [15:0] checksum_sum, checksum_sum_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [7:0]  version_ihl, version_ihl_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] flags_fragment, flags_fragment_next;
  logic [7:0]  protocol, protocol_next;
  logic [31:0] source, source_next;
  logic [31:0] destination, destination_next;

  logic [3:0]  ihl;
  logic [5:0]  hdr_bytes;
  logic        in_header;
  logic [16:0] word_sum;
  logic [7:0]  b;

  // Work out the state after this byte
  always_comb begin
    b                   = beat.data_byte;
    byte_count_next     = byte_count;
    checksum_sum_next   = checksum_sum;
    high_byte_hold_next = high_byte_hold;
    version_ihl_next    = version_ihl;
    total_length_next   = total_length;
    flags_fragment_next = flags_fragment;
    protocol_next       = protocol;
    source_next         = source;
    destination_next    = destination;

    // the first byte supplies IHL to itself
    ihl       = (byte_count == '0) ? b[3:0] : version_ihl[3:0];
    hdr_bytes = {ihl, 2'b00};
    in_header = byte_count < LENGTH_BITS'(hdr_bytes);
    word_sum  = {1'b0, checksum_sum} + {1'b0, high_byte_hold, b};

    // latch header fields by byte position
    if (byte_count == LENGTH_BITS'(0)) begin
      version_ihl_next = b;
    end else if (byte_count == LENGTH_BITS'(2) || byte_count == LENGTH_BITS'(3)) begin
      total_length_next = {total_length[7:0], b};
    end else if (byte_count == LENGTH_BITS'(6) || byte_count == LENGTH_BITS'(7)) begin
      flags_fragment_next = {flags_fragment[7:0], b};
    end else if (byte_count == LENGTH_BITS'(9)) begin
      protocol_next = b;
    end else if (byte_count >= LENGTH_BITS'(12) && byte_count <= LENGTH_BITS'(15)) begin
      source_next = {source[23:0], b};
    end else if (byte_count >= LENGTH_BITS'(16) && byte_count <= LENGTH_BITS'(19)) begin
      destination_next = {destination[23:0], b};
    end

    // accumulate header words, folding the end-around carry
    if (in_header) begin
      if (!byte_count[0]) begin
        high_byte_hold_next = b;
      end else begin
        checksum_sum_next = word_sum[15:0] + {15'd0, word_sum[16]};
      end
    end

    // saturate the count
    if (byte_count != CountMax) begin
      byte_count_next = byte_count + LENGTH_BITS'(1);
    end
  end

  // Hand the summary over on the last byte
  always_comb begin
    rec_push            = beat_valid && beat.last_byte;
    rec.byte_count      = 16'(byte_count_next);
    rec.checksum_sum    = checksum_sum_next;
    rec.version_ihl     = version_ihl_next;
    rec.total_length    = total_length_next;
    rec.flags_fragment  = flags_fragment_next;
    rec.protocol        = protocol_next;
    rec.source          = source_next;
    rec.destination     = destination_next;
  end

  // Advance per beat, clear after the last byte
  always_ff @(posedge clk) begin
    if (rst || (beat_valid && beat.last_byte)) begin
      byte_count     <= '0;
      checksum_sum   <= '0;
      high_byte_hold <= '0;
      version_ihl    <= '0;
      total_length   <= '0;
      flags_fragment <= '0;
      protocol       <= '0;
      source         <= '0;
      destination    <= '0;
    end else if (beat_valid) begin
      byte_count     <= byte_count_next;
      checksum_sum   <= checksum_sum_next;
      high_byte_hold <= high_byte_hold_next;
      version_ihl    <= version_ihl_next;
      total_length   <= total_length_next;
      flags_fragment <= flags_fragment_next;
      protocol       <= protocol_next;
      source         <= source_next;
      destination    <= destination_next;
    end
  end

endmodule

/* src/ipv4rx_queue.sv */
// Short record queue between the byte parser and the checker.
`timescale 1ns / 1ps
module ipv4rx_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  ipv4rx_pkg::hdr_rec_t wr_rec,
  output logic                 q_full,
  input  logic                 rd_en,
  output logic                 q_empty,
  output ipv4rx_pkg::hdr_rec_t rd_rec
);
  import ipv4rx_pkg::*;

  localparam int PtrBits = (RecQueueDepth > 1) ? $clog2(RecQueueDepth) : 1;
  localparam int CntBits = $clog2(RecQueueDepth + 1);

  hdr_rec_t              mem [RecQueueDepth];
  logic [PtrBits-1:0]    wr_ptr;
  logic [PtrBits-1:0]    rd_ptr;
  logic [CntBits-1:0]    fill;
  logic                  do_wr;
  logic                  do_rd;

  assign q_full  = fill == CntBits'(RecQueueDepth);
  assign q_empty = fill == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_rec  = mem[rd_ptr];

  // Store records
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrBits'(RecQueueDepth - 1)) ? '0 : wr_ptr + PtrBits'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrBits'(RecQueueDepth - 1)) ? '0 : rd_ptr + PtrBits'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CntBits'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CntBits'(1);
      end
    end
  end

endmodule

/* src/ipv4rx_back.sv */
// Checker: judges one packet summary and holds the result until popped.
`timescale 1ns / 1ps
module ipv4rx_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ipv4rx_pkg::cfg_t     cfg,
  input  logic                 rec_empty,
  input  ipv4rx_pkg::hdr_rec_t rec,
  output logic                 rec_pop,
  input  logic                 pop,
  output logic                 empty,
  output ipv4rx_pkg::result_t  result
);
  import ipv4rx_pkg::*;

  logic        res_valid;
  result_t     res_next;
  logic [3:0]  ihl;
  logic [5:0]  hdr_bytes;
  logic        dst_bcast;
  logic        dst_ok;
  logic        frag;
  logic [2:0]  verdict;

  assign rec_pop = !rec_empty && (!res_valid || pop);
  assign empty   = !res_valid;

  // Judge the packet, first failing check wins
  always_comb begin
    ihl       = rec.version_ihl[3:0];
    hdr_bytes = {ihl, 2'b00};
    dst_bcast = rec.destination == AllOnesBcast;
    if (cfg.own_address != '0) begin
      dst_ok = rec.destination == cfg.own_address || dst_bcast ||
               rec.destination == cfg.directed_broadcast ||
               rec.destination[31:28] == MulticastPrefix;
    end else begin
      dst_ok = dst_bcast;
    end
    frag = rec.flags_fragment[13] || rec.flags_fragment[12:0] != '0;

    if (rec.byte_count <= HdrMinBytes) begin
      verdict = VERDICT_SHORT;
    end else if (ihl < IhlMin) begin
      verdict = VERDICT_BAD_IHL;
    end else if (rec.byte_count <= 16'(hdr_bytes)) begin
      verdict = VERDICT_HDR_ONLY;
    end else if (rec.checksum_sum != ChecksumGood ||
                 rec.version_ihl[7:4] != IpVersion4) begin
      verdict = VERDICT_CHECKSUM;
    end else if (!dst_ok) begin
      verdict = VERDICT_NOT_OURS;
    end else if (frag) begin
      verdict = VERDICT_FRAGMENT;
    end else if (rec.byte_count < rec.total_length) begin
      verdict = VERDICT_TRUNCATED;
    end else begin
      verdict = VERDICT_ACCEPT;
    end

    // Rejected packets report the verdict alone
    res_next         = '0;
    res_next.verdict = verdict;
    if (verdict == VERDICT_ACCEPT) begin
      if (rec.protocol == ProtoIcmp) begin
        res_next.queue_select = QUEUE_ICMP;
      end else if (rec.protocol == ProtoIgmp) begin
        res_next.queue_select = QUEUE_IGMP;
      end else begin
        res_next.queue_select = QUEUE_GENERAL;
      end
      res_next.icmp_copy           = rec.protocol == ProtoIcmp && cfg.icmp_copy_enable;
      res_next.protocol_number     = rec.protocol;
      res_next.source_address      = rec.source;
      res_next.destination_address = rec.destination;
      res_next.header_bytes        = hdr_bytes;
      res_next.payload_length      = (rec.total_length >= 16'(hdr_bytes)) ?
                                     rec.total_length - 16'(hdr_bytes) : '0;
      res_next.padding_bytes       = rec.byte_count - rec.total_length;
    end
  end

  // Hold the result register
  always_ff @(posedge clk) begin
    if (rec_pop) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rec_pop) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

endmodule

/* src/ipv4_receive_header_filter.sv */
// Top level: IPv4 receive header filter with parser, record queue and checker.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------
//   input    | push / full               | item   (data_byte, last_byte)
//   result   | pop / empty               | result (verdict and header info)
//   config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One byte is taken per cycle while full is low; a packet's result reaches the result
// ports through the record queue, written at the edge that takes its last byte, and
// then the checker register, when the result side is free.
// Results wait in the checker register and a two-entry record queue; full rises
// only when both queue entries and the result register are occupied.
// Reset clears the parser state, the queue and the config registers.
`timescale 1ns / 1ps
module ipv4_receive_header_filter #(
  parameter int LENGTH_BITS = ipv4rx_pkg::LengthBitsDefault
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  ipv4rx_pkg::in_beat_t                   item,
  input  logic                                   pop,
  output logic                                   empty,
  output ipv4rx_pkg::result_t                    result,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ipv4rx_pkg::CfgIndexBits-1:0]    cfg_index,
  input  logic [31:0]                            cfg_data
);
  import ipv4rx_pkg::*;

  cfg_t     cfg;
  hdr_rec_t fr_rec;
  hdr_rec_t bk_rec;
  logic     fr_push;
  logic     q_empty;
  logic     bk_pop;
  logic     beat_valid;

  assign cfg_ready  = 1'b1;
  assign beat_valid = push && !full;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS:    cfg.own_address        <= cfg_data;
        CFG_DIRECTED_BCAST: cfg.directed_broadcast <= cfg_data;
        CFG_ICMP_COPY:      cfg.icmp_copy_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ipv4rx_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .beat_valid(beat_valid),
    .beat      (item),
    .rec_push  (fr_push),
    .rec       (fr_rec)
  );

  ipv4rx_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (fr_push),
    .wr_rec (fr_rec),
    .q_full (full),
    .rd_en  (bk_pop),
    .q_empty(q_empty),
    .rd_rec (bk_rec)
  );

  ipv4rx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rec_empty(q_empty),
    .rec      (bk_rec),
    .rec_pop  (bk_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

/* tb/ipv4_receive_header_filter_checker.sv */
// Checker for the IPv4 receive header filter: predicts each packet verdict and compares results.
`timescale 1ns / 1ps
module ipv4_receive_header_filter_checker #(
  parameter int LENGTH_BITS = ipv4rx_pkg::LengthBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  ipv4rx_pkg::in_beat_t                item,
  input  logic                                pop,
  input  logic                                empty,
  input  ipv4rx_pkg::result_t                 result,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [ipv4rx_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [31:0]                         cfg_data,
  output int                                  errors,
  output int                                  pending
);
  import ipv4rx_pkg::*;

  localparam logic [15:0] CountMax = 16'hFFFF >> (16 - LENGTH_BITS);
  localparam int ReportLimit = 10;

  // Shadow copy of the filter registers
  logic [31:0] own_addr;
  logic [31:0] bcast_addr;
  logic        copy_en;

  // Packet being received
  logic [15:0] rx_count;
  logic [15:0] rx_sum;
  logic [7:0]  rx_hold;
  logic [7:0]  rx_vihl;
  logic [15:0] rx_total_len;
  logic [15:0] rx_frag;
  logic [7:0]  rx_proto;
  logic [31:0] rx_src;
  logic [31:0] rx_dst;

  result_t verdicts_due[$];
  result_t want_beat;
  int      result_no;

  function automatic void clear_packet();
    rx_count     = '0;
    rx_sum       = '0;
    rx_hold      = '0;
    rx_vihl      = '0;
    rx_total_len = '0;
    rx_frag      = '0;
    rx_proto     = '0;
    rx_src       = '0;
    rx_dst       = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [3:0]  ihl;
    logic [15:0] hdr_len;
    logic [16:0] acc;
    ihl = (rx_count == 16'd0) ? b[3:0] : rx_vihl[3:0];
    hdr_len = {10'd0, ihl, 2'b00};
    // Latch the header fields by byte position
    case (rx_count)
      16'd0: rx_vihl = b;
      16'd2, 16'd3: rx_total_len = {rx_total_len[7:0], b};
      16'd6, 16'd7: rx_frag = {rx_frag[7:0], b};
      16'd9: rx_proto = b;
      16'd12, 16'd13, 16'd14, 16'd15: rx_src = {rx_src[23:0], b};
      16'd16, 16'd17, 16'd18, 16'd19: rx_dst = {rx_dst[23:0], b};
      default: ;
    endcase
    // Fold each completed header word into the ones-complement sum
    if (rx_count < hdr_len) begin
      if (!rx_count[0]) begin
        rx_hold = b;
      end else begin
        acc = {1'b0, rx_sum} + {1'b0, rx_hold, b};
        rx_sum = acc[15:0] + {15'd0, acc[16]};
      end
    end
    // Saturate the byte count
    if (rx_count < CountMax) rx_count = rx_count + 16'd1;
  endfunction

  function automatic void finish_packet();
    logic [15:0] hdr_len;
    logic        dst_ok;
    result_t     r;
    hdr_len = {10'd0, rx_vihl[3:0], 2'b00};
    if (own_addr != 32'd0) begin
      dst_ok = rx_dst == own_addr || rx_dst == AllOnesBcast || rx_dst == bcast_addr ||
               rx_dst[31:28] == MulticastPrefix;
    end else begin
      dst_ok = rx_dst == AllOnesBcast;
    end
    r = '0;
    // First failing check wins
    if (rx_count <= HdrMinBytes) r.verdict = VERDICT_SHORT;
    else if (rx_vihl[3:0] < IhlMin) r.verdict = VERDICT_BAD_IHL;
    else if (rx_count <= hdr_len) r.verdict = VERDICT_HDR_ONLY;
    else if (rx_sum != ChecksumGood || rx_vihl[7:4] != IpVersion4) r.verdict = VERDICT_CHECKSUM;
    else if (!dst_ok) r.verdict = VERDICT_NOT_OURS;
    else if (rx_frag[13] || rx_frag[12:0] != 13'd0) r.verdict = VERDICT_FRAGMENT;
    else if (rx_count < rx_total_len) r.verdict = VERDICT_TRUNCATED;
    else r.verdict = VERDICT_ACCEPT;
    // Fill in the header summary for accepted packets only
    if (r.verdict == VERDICT_ACCEPT) begin
      if (rx_proto == ProtoIcmp) r.queue_select = QUEUE_ICMP;
      else if (rx_proto == ProtoIgmp) r.queue_select = QUEUE_IGMP;
      else r.queue_select = QUEUE_GENERAL;
      r.icmp_copy = rx_proto == ProtoIcmp && copy_en;
      r.protocol_number = rx_proto;
      r.source_address = rx_src;
      r.destination_address = rx_dst;
      r.header_bytes = hdr_len[5:0];
      r.payload_length = (rx_total_len >= hdr_len) ? rx_total_len - hdr_len : 16'd0;
      r.padding_bytes = rx_count - rx_total_len;
    end
    verdicts_due.push_back(r);
    clear_packet();
  endfunction

  task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= ReportLimit)
        $display("%0t: result %0d field %s expected %0h, got %0h", $realtime, result_no, name,
                 want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      own_addr = '0;
      bcast_addr = '0;
      copy_en = 1'b0;
      clear_packet();
      verdicts_due.delete();
      result_no = 0;
      errors = 0;
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_ADDRESS: own_addr = cfg_data;
          CFG_DIRECTED_BCAST: bcast_addr = cfg_data;
          CFG_ICMP_COPY: copy_en = cfg_data[0];
          default: ;
        endcase
      end
      // Predict on every accepted input beat
      if (push && !full) begin
        absorb_byte(item.data_byte);
        if (item.last_byte) finish_packet();
      end
      // Compare every accepted result beat against the oldest prediction
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          if (errors <= ReportLimit)
            $display("%0t: result %0d arrived with none expected, verdict %0d", $realtime,
                     result_no, result.verdict);
        end else begin
          want_beat = verdicts_due.pop_front();
          report_field("verdict", want_beat.verdict, result.verdict);
          report_field("queue_select", want_beat.queue_select, result.queue_select);
          report_field("icmp_copy", want_beat.icmp_copy, result.icmp_copy);
          report_field("protocol_number", want_beat.protocol_number, result.protocol_number);
          report_field("source_address", want_beat.source_address, result.source_address);
          report_field("destination_address", want_beat.destination_address,
                       result.destination_address);
          report_field("header_bytes", want_beat.header_bytes, result.header_bytes);
          report_field("payload_length", want_beat.payload_length, result.payload_length);
          report_field("padding_bytes", want_beat.padding_bytes, result.padding_bytes);
        end
        result_no++;
      end
    end
    pending = verdicts_due.size();
  end

endmodule

/* tb/ipv4_receive_header_filter_test.sv */
// Testbench top: drives packets and register writes into the IPv4 receive header filter.
`timescale 1ns / 1ps
module ipv4_receive_header_filter_test;
  import ipv4rx_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int IdlePercent = 27;
  localparam int SettleCycles = 8;
  localparam int PhaseBytes = 20;
  localparam int PhasePackets = 1;
  localparam logic [31:0] HomeAddr = 32'hC0A8_0A07;
  localparam logic [31:0] HomeBcast = 32'hC0A8_0AFF;
  localparam logic [31:0] PeerAddr = 32'h0A14_1E28;

  logic                    clk;
  logic                    rst;
  logic                    push;
  logic                    full;
  in_beat_t                item;
  logic                    pop = 1'b0;
  logic                    empty;
  result_t                 result;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index;
  logic [31:0]             cfg_data;

  int          errors;
  int          pending;
  int          cycles = 0;
  bit          steady = 1'b0;
  logic [31:0] cur_own;
  logic [31:0] cur_bcast;
  logic [7:0]  pkt[$];
  int          phase_bytes;
  int          phase_packets;

  ipv4_receive_header_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ipv4_receive_header_filter_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result side at random, except during steady stretches
  always @(negedge clk) begin
    pop <= !rst && (steady || $urandom_range(0, 99) >= IdlePercent);
  end

  // Send the bytes in pkt, marking the final one
  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) begin
      while (!steady && $urandom_range(0, 99) < IdlePercent) begin
        push <= 1'b0;
        @(negedge clk);
      end
      push <= 1'b1;
      item.data_byte <= pkt[i];
      item.last_byte <= (i == pkt.size() - 1);
      @(posedge clk);
      while (full) @(posedge clk);
      @(negedge clk);
    end
    phase_bytes += pkt.size();
    phase_packets++;
  endtask

  // Build an IPv4 packet with a correct (or deliberately broken) checksum and send it
  task automatic send_ip_packet(input logic [3:0] ihl, input logic [3:0] ver,
                                input logic [15:0] tot_len, input logic [15:0] flags_frag,
                                input logic [7:0] proto, input logic [31:0] src,
                                input logic [31:0] dst, input int length, input bit bad_sum);
    logic [7:0]  hdr[60];
    int          hdr_len;
    logic [16:0] acc;
    logic [15:0] sum;
    hdr_len = ihl * 4;
    for (int i = 0; i < 60; i++) hdr[i] = 8'($urandom);
    hdr[0] = {ver, ihl};
    {hdr[2], hdr[3]} = tot_len;
    {hdr[6], hdr[7]} = flags_frag;
    hdr[9] = proto;
    {hdr[10], hdr[11]} = 16'd0;
    {hdr[12], hdr[13], hdr[14], hdr[15]} = src;
    {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
    sum = '0;
    for (int i = 0; i < hdr_len; i += 2) begin
      acc = {1'b0, sum} + {1'b0, hdr[i], hdr[i + 1]};
      sum = acc[15:0] + {15'd0, acc[16]};
    end
    sum = ~sum;
    // A single flipped bit spoils the sum whenever the header reaches the checksum field
    if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    {hdr[10], hdr[11]} = sum;
    pkt.delete();
    for (int i = 0; i < length; i++) pkt.push_back(i < 60 ? hdr[i] : 8'($urandom));
    send_packet();
  endtask

  task automatic write_reg(input logic [CfgIndexBits-1:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_filter(input logic [31:0] own, input logic [31:0] dbc,
                                input logic copy);
    write_reg(CFG_OWN_ADDRESS, own);
    write_reg(CFG_DIRECTED_BCAST, dbc);
    write_reg(CFG_ICMP_COPY, {31'd0, copy});
    cur_own = own;
    cur_bcast = dbc;
  endtask

  // Hold off until every predicted result has come out and the pipeline has settled
  task automatic wait_idle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    int          r;
    int          hlen;
    int          length;
    logic [3:0]  ihl;
    logic [3:0]  ver;
    logic [15:0] tl;
    logic [15:0] ff;
    logic [7:0]  proto;
    logic [31:0] dst;

    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    program_filter(HomeAddr, HomeBcast, 1'b1);

    // Directed packets: the checks through the address check in turn, then the accept paths
    pkt.delete();
    pkt.push_back(8'h45);
    send_packet();
    send_ip_packet(4'd5, IpVersion4, 16'd20, 16'h0000, ProtoIcmp, PeerAddr, HomeAddr, 20, 1'b0);
    send_ip_packet(4'd4, IpVersion4, 16'd21, 16'h0000, ProtoIcmp, PeerAddr, HomeAddr, 21, 1'b0);
    send_ip_packet(4'd6, IpVersion4, 16'd22, 16'h0000, ProtoIcmp, PeerAddr, HomeAddr, 22, 1'b0);
    send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h0000, ProtoIcmp, PeerAddr, HomeAddr, 21, 1'b1);
    send_ip_packet(4'd5, 4'd6, 16'd21, 16'h0000, ProtoIcmp, PeerAddr, HomeAddr, 21, 1'b0);
    send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h0000, ProtoIcmp, PeerAddr, HomeAddr + 1, 21,
                   1'b0);
    send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h0000, ProtoIcmp, PeerAddr, HomeAddr, 21, 1'b0);
    send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h0000, ProtoIgmp, 32'h0, AllOnesBcast, 21,
                   1'b0);
    send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h0000, 8'd17, 32'hFFFF_FFFF, HomeBcast, 21,
                   1'b0);
    send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h0000, 8'd0, PeerAddr, 32'hE000_0001, 21, 1'b0);
    // Run the rest of the directed set with no idling on either side
    steady = 1'b1;
    // More-fragments flag, maximum offset, then reserved plus don't-fragment (ignored)
    send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h2000, ProtoIcmp, PeerAddr, HomeAddr, 21, 1'b0);
    send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h1FFF, ProtoIcmp, PeerAddr, HomeAddr, 21, 1'b0);
    send_ip_packet(4'd5, IpVersion4, 16'd21, 16'hC000, ProtoIcmp, PeerAddr, HomeAddr, 21, 1'b0);
    // Truncated, padded, and total length below the header
    send_ip_packet(4'd5, IpVersion4, 16'd26, 16'h0000, 8'd6, PeerAddr, HomeAddr, 22, 1'b0);
    send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h0000, 8'd6, PeerAddr, HomeAddr, 24, 1'b0);
    send_ip_packet(4'd5, IpVersion4, 16'd8, 16'h0000, 8'd6, PeerAddr, HomeAddr, 21, 1'b0);
    // Largest header
    send_ip_packet(4'd15, IpVersion4, 16'd61, 16'h0000, ProtoIcmp, PeerAddr, HomeAddr, 61, 1'b0);
    steady = 1'b0;
    wait_idle();

    // Random traffic under several register settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: program_filter(HomeAddr, HomeBcast, 1'b0);
        1: program_filter(32'h0, 32'hFFFF_FFFF, 1'b1);
        2: program_filter(32'hFFFF_FFFF, 32'h0, 1'b1);
        default: program_filter($urandom, $urandom, 1'($urandom));
      endcase
      phase_bytes = 0;
      phase_packets = 0;
      steady = (ph == 2);
      // Unconfigured address: only all-ones broadcast gets through
      if (ph == 1) begin
        send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h0000, ProtoIcmp, PeerAddr, AllOnesBcast,
                       21, 1'b0);
        send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h0000, ProtoIcmp, PeerAddr, 32'h0, 21, 1'b0);
        send_ip_packet(4'd5, IpVersion4, 16'd21, 16'h0000, ProtoIcmp, PeerAddr, 32'hE000_0001,
                       21, 1'b0);
      end
      while (phase_bytes < PhaseBytes || phase_packets < PhasePackets) begin
        if ($urandom_range(0, 99) < 6) begin
          // Noise: random bytes of random length
          pkt.delete();
          length = $urandom_range(1, 40);
          for (int i = 0; i < length; i++) pkt.push_back(8'($urandom));
          send_packet();
        end else begin
          r = $urandom_range(0, 99);
          ihl = (r < 70) ? 4'd5 : (r < 94) ? 4'($urandom_range(6, 15)) : 4'($urandom_range(0, 4));
          hlen = ihl * 4;
          ver = ($urandom_range(0, 99) < 94) ? IpVersion4 : 4'($urandom);
          tl = 16'(hlen + $urandom_range(0, 24));
          if ($urandom_range(0, 99) < 5) tl = 16'($urandom_range(0, hlen));
          // Pick the received length: exact, padded, truncated or short
          r = $urandom_range(0, 99);
          if (r < 62) length = tl;
          else if (r < 80) length = tl + $urandom_range(1, 6);
          else if (r < 90) length = (tl > hlen + 1) ? $urandom_range(hlen + 1, tl - 1) : tl;
          else length = $urandom_range(1, (hlen > 20) ? hlen : 20);
          if (tl < hlen && r < 80) length = hlen + $urandom_range(1, 8);
          if (length < 1) length = 1;
          ff = {1'($urandom), 1'($urandom), 14'd0};
          if ($urandom_range(0, 99) < 12) ff[13:0] = 14'($urandom_range(1, 16383));
          r = $urandom_range(0, 3);
          proto = (r == 0) ? ProtoIcmp : (r == 1) ? ProtoIgmp : 8'($urandom);
          r = $urandom_range(0, 99);
          if (r < 35) dst = cur_own;
          else if (r < 50) dst = AllOnesBcast;
          else if (r < 65) dst = cur_bcast;
          else if (r < 80) dst = {MulticastPrefix, 28'($urandom)};
          else dst = $urandom;
          send_ip_packet(ihl, ver, tl, ff, proto, $urandom, dst, length,
                         $urandom_range(0, 99) < 6);
        end
      end
      steady = 1'b0;
      wait_idle();
    end

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
